// File: rtl/kta_pkg.sv
// Shared types and constants for the keyframe tween animator.
`timescale 1ns / 1ps
package kta_pkg;
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned Axes          = 5;
  localparam int unsigned AxisW         = 3;
  localparam int unsigned ValW          = 32;
  localparam int unsigned StepW         = 16;
  localparam int unsigned TagW          = 16;
  localparam int unsigned DivW          = 33;

  typedef enum logic [1:0] {
    CmdTick = 2'd0,
    CmdSet  = 2'd1,
    CmdAdd  = 2'd2,
    CmdNop  = 2'd3
  } cmd_e;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [DivW-1:0]   num_mag;
    logic              neg;
    logic [DivW-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ValW-1:0]   quo;
  } div_rsp_t;
endpackage

// File: rtl/kta_div.sv
// Shared restoring divider, one quotient bit per cycle, saturating signed result.
`timescale 1ns / 1ps
module kta_div
  import kta_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] rem_q, quo_q, den_q;
  logic            neg_q, run_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW:0]   trial;
  logic [DivW-1:0] rem_sh;
  logic [DivW:0]   sval;
  logic [ValW-1:0] res;

  assign rem_sh = {rem_q[DivW-2:0], quo_q[DivW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(DivW);
        rem_q <= '0;
        quo_q <= req_i.num_mag;
        den_q <= req_i.den;
        neg_q <= req_i.neg;
      end else if (run_q) begin
        if (!trial[DivW]) begin
          rem_q <= trial[DivW-1:0];
          quo_q <= {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[DivW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Apply sign and saturate to 32 bits.
  always_comb begin
    sval = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
    if (!neg_q && quo_q > DivW'(32'h7fff_ffff)) res = 32'h7fff_ffff;
    else if (neg_q && quo_q > DivW'(33'h0_8000_0000)) res = 32'h8000_0000;
    else res = sval[ValW-1:0];
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = res;
endmodule

// File: rtl/kta_advance.sv
// Shared saturating add unit for one axis, with optional ease-out multiply.
`timescale 1ns / 1ps
module kta_advance
  import kta_pkg::*;
(
  input  logic             clk_i,
  input  logic [ValW-1:0]  cur_i,
  input  logic [ValW-1:0]  delta_i,
  input  logic [StepW-1:0] steps_i,
  input  logic             ease_i,
  output logic [ValW-1:0]  sum_o
);
  logic signed [ValW+StepW:0] prod_q;
  logic signed [ValW+StepW+1:0] tot;

  // Registered product, used in the next cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= ease_i ? $signed(delta_i) * $signed({1'b0, steps_i})
                     : (ValW+StepW+1)'($signed(delta_i));
  end

  always_comb begin
    tot = (ValW+StepW+2)'($signed(cur_i)) + (ValW+StepW+2)'(prod_q);
    if (tot > (ValW+StepW+2)'(64'sh7fff_ffff)) sum_o = 32'h7fff_ffff;
    else if (tot < -(ValW+StepW+2)'(64'sh8000_0000)) sum_o = 32'h8000_0000;
    else sum_o = tot[ValW-1:0];
  end
endmodule

// File: rtl/keyframe_tween_animator_top.sv
// Top level of the keyframe tween animator: sequencer, state and phase queue.
`timescale 1ns / 1ps
// One request is taken at a time. A tick while playing walks the five axes
// through one shared add unit, a multiply state and an add state per axis.
// Starting a phase runs five divisions in turn through one bit-serial divider,
// each axis with its own load and wait states. Set transform and idle ticks go
// from decode straight to the result. The queue is a memory read one entry at
// a time; its entries are undefined until written and need no clearing pass.
// The result waits in an output register until taken.
module keyframe_tween_animator_top
  import kta_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [ValW-1:0]   target_trans_x_i,
  input  logic [ValW-1:0]   target_trans_y_i,
  input  logic [ValW-1:0]   target_scale_x_i,
  input  logic [ValW-1:0]   target_scale_y_i,
  input  logic [ValW-1:0]   target_rot_z_i,
  input  logic [StepW-1:0]  step_count_i,
  input  logic              ease_mode_i,
  input  logic              force_start_i,
  input  logic              has_tag_i,
  input  logic [TagW-1:0]   phase_tag_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValW-1:0]   cur_trans_x_o,
  output logic [ValW-1:0]   cur_trans_y_o,
  output logic [ValW-1:0]   cur_scale_x_o,
  output logic [ValW-1:0]   cur_scale_y_o,
  output logic [ValW-1:0]   cur_rot_z_o,
  output logic              changed_flag_o,
  output logic              end_event_o,
  output logic [TagW-1:0]   end_tag_o,
  output logic              busy_res_o,
  output logic              queue_overflow_o
);
  // Q format is raw two's complement, so the fraction width does not change
  // any datapath; it only fixes the meaning of the bits.
  localparam int unsigned FracW = FRAC_BITS;
  localparam int unsigned QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MetaW = StepW + 2 + TagW;
  localparam int unsigned QAW   = $clog2(QUEUE_DEPTH * Axes);

  typedef enum logic [3:0] {
    SIdle, SDecode, SAdvMul, SAdvAdd, SStartRd, SStartMeta,
    SDivLoad, SDivWait, SDone
  } state_e;

  state_e          state_q;
  logic [ValW-1:0] cur_q   [Axes];
  logic [ValW-1:0] delta_q [Axes];
  logic [StepW-1:0] rem_q;
  logic            play_q, ease_q, tagged_q;
  logic [TagW-1:0] tag_q;
  logic [QW-1:0]   head_q;
  logic [CntW-1:0] count_q;
  logic [AxisW-1:0] axis_q;

  // Latched request.
  cmd_e            cmd_q;
  logic [ValW-1:0] tgt_q [Axes];
  logic [StepW-1:0] steps_in_q;
  logic            ease_in_q, force_q, htag_in_q;
  logic [TagW-1:0] ptag_q;

  // Phase queue memories.
  logic [ValW-1:0]  qtgt_mem  [QUEUE_DEPTH*Axes];
  logic [MetaW-1:0] qmeta_mem [QUEUE_DEPTH];
  logic [ValW-1:0]  qtgt_rd_q;
  logic [MetaW-1:0] qmeta_rd_q;
  logic             qwe;
  logic [QW:0]      qwr_sum;
  logic [QW-1:0]    qwr_slot;
  logic [QAW-1:0]   qt_waddr, qt_raddr;
  logic [StepW-1:0] wsteps;

  // Starting phase parameters.
  logic [StepW-1:0] nsteps_q;
  logic             nease_q;
  logic [DivW-1:0]  den_q;

  // Result register.
  logic            ov_q, chg_q, end_q, vld_q;
  logic [TagW-1:0] etag_q;

  div_req_t dreq;
  div_rsp_t drsp;
  logic [ValW-1:0] adv_sum;
  logic [DivW-1:0] axis_dist;
  logic [2*StepW:0] ease_prod;

  assign wsteps   = (steps_in_q == '0) ? StepW'(1) : steps_in_q;
  // Tail slot wraps at the queue depth, which need not be a power of two.
  assign qwr_sum  = (QW+1)'(head_q) + (QW+1)'(count_q);
  assign qwr_slot = force_q ? '0 :
                    (qwr_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                    QW'(qwr_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(qwr_sum);
  assign qwe      = (state_q == SDecode) && (cmd_q == CmdAdd) &&
                    (force_q || count_q < CntW'(QUEUE_DEPTH));
  assign qt_waddr = QAW'(qwr_slot) * QAW'(Axes) + QAW'(axis_q);
  assign qt_raddr = QAW'(head_q) * QAW'(Axes) + QAW'(axis_q);
  assign axis_dist = DivW'($signed(qtgt_rd_q)) - DivW'($signed(cur_q[axis_q]));
  assign ease_prod = nsteps_q * ({1'b0, nsteps_q} + 1'b1);

  // Target memory: five words written, one per axis, while decoding an add that the queue can take.
  always_ff @(posedge clk_i) begin
    if (qwe) qtgt_mem[qt_waddr] <= tgt_q[axis_q];
    qtgt_rd_q <= qtgt_mem[qt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (qwe && axis_q == '0) qmeta_mem[qwr_slot] <= {wsteps, ease_in_q, htag_in_q, ptag_q};
    qmeta_rd_q <= qmeta_mem[head_q];
  end

  always_comb begin
    dreq.start   = (state_q == SDivLoad);
    dreq.neg     = axis_dist[DivW-1];
    dreq.num_mag = axis_dist[DivW-1] ? -axis_dist : axis_dist;
    dreq.den     = den_q;
  end

  kta_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  kta_advance u_adv (
    .clk_i, .cur_i(cur_q[axis_q]), .delta_i(delta_q[axis_q]),
    .steps_i(rem_q), .ease_i(ease_q), .sum_o(adv_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      for (int i = 0; i < Axes; i++) begin
        cur_q[i]   <= '0;
        delta_q[i] <= '0;
        tgt_q[i]   <= '0;
      end
      rem_q    <= '0;
      play_q   <= 1'b0;
      ease_q   <= 1'b0;
      tagged_q <= 1'b0;
      tag_q    <= '0;
      head_q   <= '0;
      count_q  <= '0;
      axis_q   <= '0;
      vld_q    <= 1'b0;
      cmd_q    <= CmdNop;
      steps_in_q <= '0;
      ease_in_q  <= 1'b0;
      force_q    <= 1'b0;
      htag_in_q  <= 1'b0;
      ptag_q     <= '0;
      chg_q    <= 1'b0;
      end_q    <= 1'b0;
      etag_q   <= '0;
      ov_q     <= 1'b0;
      nsteps_q <= '0;
      nease_q  <= 1'b0;
      den_q    <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            cmd_q <= cmd_e'(command_i);
            tgt_q[0] <= target_trans_x_i;
            tgt_q[1] <= target_trans_y_i;
            tgt_q[2] <= target_scale_x_i;
            tgt_q[3] <= target_scale_y_i;
            tgt_q[4] <= target_rot_z_i;
            steps_in_q <= step_count_i;
            ease_in_q  <= ease_mode_i;
            force_q    <= force_start_i;
            htag_in_q  <= has_tag_i;
            ptag_q     <= phase_tag_i;
            chg_q <= 1'b0;
            end_q <= 1'b0;
            etag_q <= '0;
            ov_q  <= 1'b0;
            axis_q <= '0;
            state_q <= SDecode;
          end
        end
        SDecode: begin
          case (cmd_q)
            CmdTick: begin
              if (!play_q) state_q <= SDone;
              else if (rem_q != '0) begin
                state_q <= SAdvMul;
                chg_q   <= 1'b1;
              end else begin
                end_q    <= tagged_q;
                etag_q   <= tagged_q ? tag_q : '0;
                tagged_q <= 1'b0;
                play_q   <= 1'b0;
                if (count_q != '0) begin
                  chg_q   <= 1'b1;
                  state_q <= SStartRd;
                end else state_q <= SDone;
              end
            end
            CmdSet: begin
              for (int i = 0; i < Axes; i++) cur_q[i] <= tgt_q[i];
              state_q <= SDone;
            end
            CmdAdd: begin
              // Write the five target words, one axis at a time.
              if (axis_q == AxisW'(Axes - 1)) begin
                axis_q <= '0;
                if (force_q) begin
                  head_q  <= '0;
                  count_q <= CntW'(1);
                end else if (count_q < CntW'(QUEUE_DEPTH)) count_q <= count_q + 1'b1;
                else ov_q <= 1'b1;
                if (!play_q || force_q ||
                    (count_q == '0 && !(count_q < CntW'(QUEUE_DEPTH)))) begin
                  play_q  <= 1'b0;
                  state_q <= SStartRd;
                end else state_q <= SDone;
              end else axis_q <= axis_q + 1'b1;
            end
            default: state_q <= SDone;
          endcase
        end
        SAdvMul: state_q <= SAdvAdd;
        SAdvAdd: begin
          cur_q[axis_q] <= adv_sum;
          if (axis_q == AxisW'(Axes - 1)) begin
            axis_q  <= '0;
            rem_q   <= rem_q - 1'b1;
            state_q <= SDone;
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= SAdvMul;
          end
        end
        SStartRd: begin
          // Memory read of head entry; count may be zero only if nothing queued.
          if (count_q == '0) state_q <= SDone;
          else state_q <= SStartMeta;
        end
        SStartMeta: begin
          nsteps_q <= qmeta_rd_q[MetaW-1 -: StepW];
          nease_q  <= qmeta_rd_q[TagW+1];
          tagged_q <= qmeta_rd_q[TagW];
          tag_q    <= qmeta_rd_q[TagW-1:0];
          state_q  <= SDivLoad;
          den_q    <= '0;
        end
        SDivLoad: begin
          if (den_q == '0) begin
            // First pass computes the divisor and lets the target read for
            // this axis settle, then the load is repeated.
            den_q <= nease_q ? DivW'(ease_prod >> 1) : DivW'(nsteps_q);
          end else state_q <= SDivWait;
        end
        SDivWait: begin
          if (drsp.done) begin
            delta_q[axis_q] <= drsp.quo;
            if (axis_q == AxisW'(Axes - 1)) begin
              axis_q  <= '0;
              rem_q   <= nsteps_q;
              ease_q  <= nease_q;
              play_q  <= 1'b1;
              head_q  <= (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
              count_q <= count_q - 1'b1;
              state_q <= SDone;
            end else begin
              axis_q  <= axis_q + 1'b1;
              den_q   <= '0;
              state_q <= SDivLoad;
            end
          end
        end
        SDone: begin
          if (!vld_q) begin
            vld_q <= 1'b1;
          end else if (out_ready_i) begin
            vld_q   <= 1'b0;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_ready_o       = (state_q == SIdle);
  assign out_valid_o      = vld_q;
  assign cur_trans_x_o    = cur_q[0];
  assign cur_trans_y_o    = cur_q[1];
  assign cur_scale_x_o    = cur_q[2];
  assign cur_scale_y_o    = cur_q[3];
  assign cur_rot_z_o      = cur_q[4];
  assign changed_flag_o   = chg_q;
  assign end_event_o      = end_q;
  assign end_tag_o        = etag_q;
  assign busy_res_o       = play_q;
  assign queue_overflow_o = ov_q;

  // Unused apart from documenting the format width.
  logic frac_unused;
  assign frac_unused = (FracW == 0);

  // The queue never holds more phases than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH)) else $error("queue count beyond depth");
  // No new request while a result is pending.
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready with pending result");
  // An end event only comes from a tick.
  a_end_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_event_o) |-> (cmd_q == CmdTick)) else $error("end event off tick");
  // Overflow and change never appear together.
  a_ov_chg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(queue_overflow_o && changed_flag_o)) else $error("overflow with change");
endmodule
